@@ src/signed_mask_integral_image_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed mask integral image core
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MASK_INTEGRAL_IMAGE_CORE_MACROS_SVH
`define SIGNED_MASK_INTEGRAL_IMAGE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMII_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMII_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/smii_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed mask integral image package
// Field widths, register codes and reset values shared by the core.
// ----------------------------------------------------------------------------
package smii_pkg;

    localparam int PIXEL_W     = 8;
    localparam int SUM_W       = 22;
    localparam int INDEX_W     = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [PIXEL_W-1:0] FULL_SCORE = 8'd255;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

@@ src/signed_mask_integral_image_core.sv @@
// ----------------------------------------------------------------------------
// Signed mask integral image core
// Streams mask pixels in raster order and returns the signed summed-area
// value of each pixel together with its row, column and an end-of-frame flag.
// ----------------------------------------------------------------------------
// The core sustains one pixel beat per clock cycle while out_ready is high.
// Each accepted pixel reads the previous row's integral from the line store
// into the summing stage, which adds the current row's running sum and
// writes the result back to the same column as it moves into the result
// register. The line store has one read and one write port, and a result
// written in one cycle is forwarded to a read of the same column issued at
// that edge, so a frame only one pixel wide also runs at full rate. A pixel
// of 255 scores plus one and any other value scores minus one. The first row
// of each frame ignores the line store, so every frame starts afresh. After
// reset the line store is cleared to zero one column per cycle; in_ready
// stays low meanwhile, though configuration writes are taken at any time.
// Frame sizes of zero are treated as one and sizes above MAX_WIDTH or
// MAX_HEIGHT are saturated. Configuration should only be written while no
// pixels are in flight.
// ----------------------------------------------------------------------------
`include "signed_mask_integral_image_core_macros.svh"

module signed_mask_integral_image_core
    import smii_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_W-1:0]        mask_pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SUM_W-1:0]   area_sum,
    output logic [INDEX_W-1:0]        row_index,
    output logic [INDEX_W-1:0]        column_index,
    output logic                      frame_end
);

    // Column and row counters index positions below the maximum sizes; the
    // clamped sizes themselves need one more value.
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    // The row running sum lies within plus or minus MAX_WIDTH.
    localparam int RUNW = CW + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective frame size: zero reads as one, oversize saturates.
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_eff = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            height_eff = HW'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            height_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HW'(frame_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and clearing pass
    // ------------------------------------------------------------------
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    logic          out_valid_reg;
    logic          advance;
    logic          accept;
    logic          write_s1;

    // The result register frees up whenever it is empty or being taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign accept   = in_valid && in_ready;
    assign write_s1 = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == CW'(MAX_WIDTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: counters and the row running sum
    // ------------------------------------------------------------------
    logic [CW-1:0]          col_count_reg;
    logic [CW-1:0]          col_count_next;
    logic [RW-1:0]          row_count_reg;
    logic [RW-1:0]          row_count_next;
    logic signed [RUNW-1:0] run_reg;
    logic signed [RUNW-1:0] run_next;
    logic signed [RUNW-1:0] run_new;
    logic signed [RUNW-1:0] score;
    logic                   last_col;
    logic                   last_row;

    assign score    = (mask_pixel == FULL_SCORE) ? RUNW'(1) : '1;
    assign run_new  = (col_count_reg == '0) ? score : run_reg + score;
    assign last_col = (WW'(col_count_reg) + WW'(1)) >= width_eff;
    assign last_row = (HW'(row_count_reg) + HW'(1)) >= height_eff;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        run_next       = run_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                run_next       = '0;
                row_count_next = last_row ? '0 : row_count_reg + RW'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
                run_next       = run_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            run_reg       <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            run_reg       <= run_next;
        end
    end

    // ------------------------------------------------------------------
    // Summing stage: holds the accepted pixel while the line store reads
    // ------------------------------------------------------------------
    logic [CW-1:0]          s1_col_reg;
    logic [RW-1:0]          s1_row_reg;
    logic signed [RUNW-1:0] s1_run_reg;
    logic                   s1_row_nz_reg;
    logic                   s1_end_reg;
    logic                   fwd_hit_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;
    logic signed [SUM_W-1:0] prior;
    logic signed [SUM_W-1:0] s1_sum;
    logic [SUM_W-1:0]       ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // When the pixel leaving this stage writes the column that the new pixel
    // reads at the same edge, the memory returns stale data, so the written
    // sum is kept aside and used instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= col_count_reg;
            s1_row_reg    <= row_count_reg;
            s1_run_reg    <= run_new;
            s1_row_nz_reg <= row_count_reg != '0;
            s1_end_reg    <= last_col && last_row;
            fwd_hit_reg   <= write_s1 && (s1_col_reg == col_count_reg);
            fwd_data_reg  <= s1_sum;
        end
    end

    always_comb
    begin
        if (!s1_row_nz_reg)
        begin
            prior = '0;
        end
        else if (fwd_hit_reg)
        begin
            prior = fwd_data_reg;
        end
        else
        begin
            prior = $signed(ram_rd_data);
        end
    end

    assign s1_sum = prior + SUM_W'(s1_run_reg);

    // ------------------------------------------------------------------
    // Line store of the previous row's integrals
    // ------------------------------------------------------------------
    logic                 ram_wr_en;
    logic [CW-1:0]        ram_wr_addr;
    logic [SUM_W-1:0]     ram_wr_data;

    assign ram_wr_en   = clr_busy_reg || write_s1;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wr_data = clr_busy_reg ? '0 : s1_sum;

    smii_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] area_sum_reg;
    logic [INDEX_W-1:0]      row_index_reg;
    logic [INDEX_W-1:0]      column_index_reg;
    logic                    frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_s1)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_s1)
        begin
            area_sum_reg     <= s1_sum;
            row_index_reg    <= INDEX_W'(s1_row_reg);
            column_index_reg <= INDEX_W'(s1_col_reg);
            frame_end_reg    <= s1_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign area_sum     = area_sum_reg;
    assign row_index    = row_index_reg;
    assign column_index = column_index_reg;
    assign frame_end    = frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SMII_ASSERT_NOW(a_clear_blocks_input, clr_busy_reg, !in_ready,
        "pixel taken while line store clears")
    `SMII_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_col_reg), "summing stage lost a stalled pixel")
    `SMII_ASSERT_NEXT(a_column_steps, accept && !last_col,
        col_count_reg == $past(col_count_reg) + CW'(1), "column counter did not step")
    `SMII_ASSERT_NEXT(a_frame_wraps, accept && last_col && last_row,
        col_count_reg == '0 && row_count_reg == '0 && run_reg == '0,
        "counters did not wrap at frame end")

endmodule

@@ src/smii_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module smii_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
